/* rtl/srmb_pkg.sv */
// Package for the selective receive mailbox.
// Holds operation and error codes, field widths and the cell command struct.
// No dependencies.
package srmb_pkg;

  // Field widths fixed by the item format
  localparam int VALUE_W   = 64;
  localparam int LABEL_W   = 32;
  localparam int OP_W      = 3;
  localparam int ERR_W     = 2;
  localparam int IN_DATA_W = VALUE_W + LABEL_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_READ    = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_STEP    = 3'd3,
    OP_MARK    = 3'd4,
    OP_RESTORE = 3'd5
  } op_t;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Command broadcast to every slot cell
  typedef struct packed {
    logic append;  // write the slot at the tail index
    logic remove;  // slots at or above the cursor take their upper neighbor
  } cell_cmd_t;

endpackage

/* rtl/selective_receive_mailbox.sv */
// Selective receive mailbox: an ordered store of MAILBOX_DEPTH 64-bit
// messages with a scan cursor, a labeled mark and one result per operation.
// Each operation is applied in the cycle it is accepted; the result is then
// set by the read chain that carries the word at the cursor through one slot
// cell per cycle to the end of the row, and is loaded once the settle counter
// has run out. One operation is in flight at a time, so the next item is
// accepted only after the result is loaded; a pending result waiting on
// m_tready does not block the next item.
// Depends on srmb_pkg, srmb_cell and srmb_ctrl.
module selective_receive_mailbox
  import srmb_pkg::*;
#(
  parameter int MAILBOX_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [63:0] message_value, [95:64] code_label
  input  logic [IN_DATA_W-1:0] s_tdata,
  // [2:0] operation
  input  logic [OP_W-1:0]      s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [63:0] current_value, [64] current_present, [66:65] error_code,
  // then message_count, zero filled to whole bytes
  output logic [((VALUE_W + 1 + ERR_W + $clog2(MAILBOX_DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int CNT_W = $clog2(MAILBOX_DEPTH + 1);
  localparam int OUT_W = ((VALUE_W + 1 + ERR_W + CNT_W + 7) / 8) * 8;

  cell_cmd_t          cmd;
  logic [CNT_W-1:0]   cursor;
  logic [CNT_W-1:0]   count;
  logic [VALUE_W-1:0] current_value;
  logic               current_present;
  logic [ERR_W-1:0]   error_code;
  logic [CNT_W-1:0]   message_count;
  logic [VALUE_W-1:0] message_value;
  logic [LABEL_W-1:0] code_label;
  logic [VALUE_W-1:0] slot_w [MAILBOX_DEPTH];
  logic [VALUE_W-1:0] rd_w   [MAILBOX_DEPTH];

  assign message_value = s_tdata[VALUE_W-1:0];
  assign code_label    = s_tdata[IN_DATA_W-1:VALUE_W];

  srmb_ctrl #(
    .MAILBOX_DEPTH(MAILBOX_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .operation      (s_tuser),
    .code_label     (code_label),
    .rd_end         (rd_w[MAILBOX_DEPTH-1]),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .current_value  (current_value),
    .current_present(current_present),
    .error_code     (error_code),
    .message_count  (message_count),
    .cmd            (cmd),
    .cursor         (cursor),
    .count          (count)
  );

  // Row of slot cells; each takes its upper neighbor on remove
  for (genvar i = 0; i < MAILBOX_DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] shift_src;
    logic [VALUE_W-1:0] rd_src;

    if (i == MAILBOX_DEPTH - 1) begin : g_top
      assign shift_src = slot_w[i];
    end else begin : g_mid
      assign shift_src = slot_w[i+1];
    end

    if (i == 0) begin : g_first
      assign rd_src = '0;
    end else begin : g_rest
      assign rd_src = rd_w[i-1];
    end

    srmb_cell #(
      .CNT_W     (CNT_W),
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .cursor  (cursor),
      .count   (count),
      .wdata   (message_value),
      .shift_in(shift_src),
      .slot    (slot_w[i]),
      .rd_in   (rd_src),
      .rd_out  (rd_w[i])
    );
  end

  // Result packing
  assign m_tdata = OUT_W'({message_count, error_code, current_present, current_value});

endmodule

/* rtl/srmb_cell.sv */
// One slot cell of the mailbox chain: holds a message word and one stage
// of the read chain that carries the word at the cursor toward the end.
// Depends on srmb_pkg.
module srmb_cell
  import srmb_pkg::*;
#(
  parameter int CNT_W      = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]   cursor,
  input  logic [CNT_W-1:0]   count,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [VALUE_W-1:0] shift_in,
  output logic [VALUE_W-1:0] slot,
  input  logic [VALUE_W-1:0] rd_in,
  output logic [VALUE_W-1:0] rd_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_INDEX);

  // Slot update: tail write on append, gap close on remove
  always_ff @(posedge clk) begin
    if (cmd.append && (count == MY_IDX)) begin
      slot <= wdata;
    end else if (cmd.remove && (MY_IDX >= cursor)) begin
      slot <= shift_in;
    end
  end

  // Read chain: the cursor cell injects its word, others pass the neighbor's
  always_ff @(posedge clk) begin
    rd_out <= (cursor == MY_IDX) ? slot : rd_in;
  end

endmodule

/* rtl/srmb_ctrl.sv */
// Mailbox control: handshakes, count, cursor and mark registers, the
// settle counter for the read chain and the result register.
// Depends on srmb_pkg.
module srmb_ctrl
  import srmb_pkg::*;
#(
  parameter int MAILBOX_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [OP_W-1:0]                      operation,
  input  logic [LABEL_W-1:0]                   code_label,
  input  logic [VALUE_W-1:0]                   rd_end,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [VALUE_W-1:0]                   current_value,
  output logic                                 current_present,
  output logic [ERR_W-1:0]                     error_code,
  output logic [$clog2(MAILBOX_DEPTH+1)-1:0]   message_count,
  output cell_cmd_t                            cmd,
  output logic [$clog2(MAILBOX_DEPTH+1)-1:0]   cursor,
  output logic [$clog2(MAILBOX_DEPTH+1)-1:0]   count
);

  localparam int CNT_W = $clog2(MAILBOX_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAILBOX_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   wait_cnt;
  logic [CNT_W-1:0]   mark_index;
  logic [LABEL_W-1:0] mark_label;
  logic               mark_valid;
  logic [ERR_W-1:0]   err;

  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   cursor_next;
  logic [CNT_W-1:0]   mark_index_next;
  logic [LABEL_W-1:0] mark_label_next;
  logic               mark_valid_next;
  logic [ERR_W-1:0]   err_next;
  logic               accept;
  logic               out_free;
  logic               out_load;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_WAIT) && (wait_cnt == '0) && out_free;

  // Operation decode, applied at the accept edge
  always_comb begin
    count_next      = count;
    cursor_next     = cursor;
    mark_index_next = mark_index;
    mark_label_next = mark_label;
    mark_valid_next = mark_valid;
    err_next        = ERR_OK;
    cmd             = '0;
    if (accept) begin
      unique case (op_t'(operation))
        OP_APPEND: begin
          if (count == DEPTH_C) begin
            err_next = ERR_FULL;
          end else begin
            cmd.append = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_READ: begin
        end
        OP_REMOVE: begin
          if (cursor < count) begin
            cmd.remove = 1'b1;
            count_next = count - CNT_W'(1);
            if (mark_valid && (cursor < mark_index)) begin
              mark_index_next = mark_index - CNT_W'(1);
            end
          end else begin
            err_next = ERR_EMPTY;
          end
          cursor_next = '0;
        end
        OP_STEP: begin
          cursor_next = (cursor < count) ? cursor + CNT_W'(1) : '0;
        end
        OP_MARK: begin
          mark_label_next = code_label;
          mark_index_next = count;
          mark_valid_next = 1'b1;
        end
        OP_RESTORE: begin
          if (mark_valid && (mark_label == code_label)) begin
            cursor_next = (mark_index > count) ? count : mark_index;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State, mailbox registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      wait_cnt        <= '0;
      count           <= '0;
      cursor          <= '0;
      mark_index      <= '0;
      mark_label      <= '0;
      mark_valid      <= 1'b0;
      err             <= ERR_OK;
      m_tvalid        <= 1'b0;
      current_value   <= '0;
      current_present <= 1'b0;
      error_code      <= ERR_OK;
      message_count   <= '0;
    end else begin
      count      <= count_next;
      cursor     <= cursor_next;
      mark_index <= mark_index_next;
      mark_label <= mark_label_next;
      mark_valid <= mark_valid_next;
      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            err      <= err_next;
            wait_cnt <= DEPTH_C;
            state    <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - CNT_W'(1);
          end else if (out_free) begin
            m_tvalid        <= 1'b1;
            current_present <= (cursor < count);
            current_value   <= (cursor < count) ? rd_end : '0;
            error_code      <= err;
            message_count   <= count;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/srmb_check.sv */
// Port-level checks for the selective receive mailbox, bound to the top.
// Depends on srmb_pkg and selective_receive_mailbox.
module srmb_check
  import srmb_pkg::*;
#(
  parameter int MAILBOX_DEPTH = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [((VALUE_W + 1 + ERR_W + $clog2(MAILBOX_DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int CNT_W = $clog2(MAILBOX_DEPTH + 1);
  localparam int CNT_LO = VALUE_W + 1 + ERR_W;

  logic [VALUE_W-1:0] r_value;
  logic               r_present;
  logic [ERR_W-1:0]   r_err;
  logic [CNT_W-1:0]   r_count;

  assign r_value   = m_tdata[VALUE_W-1:0];
  assign r_present = m_tdata[VALUE_W];
  assign r_err     = m_tdata[VALUE_W+ERR_W:VALUE_W+1];
  assign r_count   = m_tdata[CNT_LO+CNT_W-1:CNT_LO];

  // No message at the cursor reads as zero
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r_present |-> r_value == '0)
    else $error("absent message with nonzero value");

  // A dropped append means the store is full; count never exceeds depth
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r_err == ERR_FULL) |-> r_count == CNT_W'(MAILBOX_DEPTH))
    else $error("full error with store not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r_count <= CNT_W'(MAILBOX_DEPTH)) && (r_err != 2'd3)
      && !(r_present && (r_count == '0)))
    else $error("result fields out of range");

  // One item in flight: no acceptance right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted two items back to back");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind selective_receive_mailbox srmb_check #(
  .MAILBOX_DEPTH(MAILBOX_DEPTH)
) u_srmb_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* verif/selective_receive_mailbox_test.sv */
// Testbench for selective_receive_mailbox: a directed stimulus table, then random operation mixes, with every
// result checked against the table's expected item or an in-bench mailbox predictor.
// Depends on srmb_pkg and the selective_receive_mailbox RTL.
module selective_receive_mailbox_test;
  import srmb_pkg::*;

  localparam int DEPTH        = 16;
  localparam int COUNT_W      = $clog2(DEPTH + 1);
  localparam int RESULT_W     = VALUE_W + 1 + ERR_W + COUNT_W;
  localparam int OUT_W        = ((RESULT_W + 7) / 8) * 8;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_WAIT     = 6;

  // Codes outside the defined operations; the block must treat them as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic [VALUE_W-1:0] ALL_ONES_WORD  = '1;
  localparam logic [LABEL_W-1:0] ALL_ONES_LABEL = '1;

  // One result item, laid out as in m_tdata (count in the top bits)
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ERR_W-1:0]   err;
    logic               present;
    logic [VALUE_W-1:0] word;
  } mbox_result_t;

  // Directed stimulus row; reps > 1 repeats the row, appends then carry random words
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] word;
    logic [LABEL_W-1:0] label;
    int                 reps;
    logic               typed;
    mbox_result_t       want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty mailbox right after reset
    '{OP_READ,    64'd0, 32'd0, 1, 1'b1, '{5'd0, ERR_OK,    1'b0, 64'd0}},
    '{OP_REMOVE,  64'd0, 32'd0, 1, 1'b1, '{5'd0, ERR_EMPTY, 1'b0, 64'd0}},
    '{OP_STEP,    64'd0, 32'd0, 1, 1'b1, '{5'd0, ERR_OK,    1'b0, 64'd0}},
    '{OP_RESTORE, 64'd0, 32'd0, 1, 1'b1, '{5'd0, ERR_OK,    1'b0, 64'd0}},
    // cursor at end lands on the first appended word
    '{OP_APPEND, ALL_ONES_WORD, 32'd0, 1, 1'b1, '{5'd1, ERR_OK, 1'b1, ALL_ONES_WORD}},
    '{OP_APPEND, 64'd0,         32'd0, 1, 1'b1, '{5'd2, ERR_OK, 1'b1, ALL_ONES_WORD}},
    '{OP_MARK,   64'd0, ALL_ONES_LABEL, 1, 1'b0, '0},
    '{OP_APPEND, 64'h0123_4567_89ab_cdef, 32'd0, 1, 1'b0, '0},
    // walk to the end and wrap to the head
    '{OP_STEP,    64'd0, 32'd0, 4, 1'b0, '0},
    // wrong label leaves the cursor, right label jumps past older words
    '{OP_RESTORE, 64'd0, 32'd0,          1, 1'b0, '0},
    '{OP_RESTORE, 64'd0, ALL_ONES_LABEL, 1, 1'b0, '0},
    '{OP_READ,    64'd0, 32'd0,          1, 1'b0, '0},
    '{OP_REMOVE,  64'd0, 32'd0,          1, 1'b0, '0},
    '{OP_APPEND,  64'h8000_0000_0000_0001, 32'd0, 1, 1'b0, '0},
    // removal below the mark pulls the mark down
    '{OP_REMOVE,  64'd0, 32'd0,          1, 1'b0, '0},
    '{OP_RESTORE, 64'd0, ALL_ONES_LABEL, 1, 1'b0, '0},
    '{OP_SPARE_A, ALL_ONES_WORD, ALL_ONES_LABEL, 1, 1'b0, '0},
    '{OP_SPARE_B, ALL_ONES_WORD, ALL_ONES_LABEL, 1, 1'b0, '0},
    '{OP_REMOVE,  64'd0, 32'd0,          1, 1'b0, '0},
    // fill up, then one append too many
    '{OP_APPEND, 64'd0, 32'd0, DEPTH - 1, 1'b0, '0},
    '{OP_APPEND, 64'h5555_aaaa_5555_aaaa, 32'd0, 1, 1'b1, '{5'd16, ERR_FULL, 1'b1, 64'd0}},
    // full walk with wrap while full
    '{OP_STEP,    64'd0, 32'd0, DEPTH + 1, 1'b0, '0},
    '{OP_MARK,    64'd0, 32'd0, 1, 1'b0, '0},
    '{OP_REMOVE,  64'd0, 32'd0, 1, 1'b0, '0},
    '{OP_RESTORE, 64'd0, 32'd0, 1, 1'b0, '0}
  };

  // Random mix cut points per mode: fill, drain, scan.
  // Order: append, read, remove, step, mark, restore; the rest are spare codes.
  localparam int OP_CUTS [3][6] = '{
    '{50, 58, 68, 80, 88, 98},
    '{15, 23, 63, 78, 85, 98},
    '{25, 35, 50, 75, 85, 98}
  };
  localparam logic [OP_W-1:0] OP_ORDER [6] = '{
    OP_APPEND, OP_READ, OP_REMOVE, OP_STEP, OP_MARK, OP_RESTORE
  };

  logic [LABEL_W-1:0] label_pool [4] = '{32'd0, ALL_ONES_LABEL, 32'h0000_0100, 32'ha5a5_5a5a};

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [OP_W-1:0]      s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;

  // Predictor state
  logic [VALUE_W-1:0] mb_slots [DEPTH];
  int                 mb_count;
  int                 mb_cursor;
  int                 mark_pos;
  logic [LABEL_W-1:0] mark_tag;
  logic               mark_set;

  mbox_result_t pending_results [$];
  int           error_count;
  logic         send_calm;

  selective_receive_mailbox #(
    .MAILBOX_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one operation to the predictor and returns the result it must produce
  function automatic mbox_result_t mailbox_apply(logic [OP_W-1:0] op,
                                                 logic [VALUE_W-1:0] word,
                                                 logic [LABEL_W-1:0] label);
    mbox_result_t res;
    res = '0;
    res.err = ERR_OK;
    if (mb_cursor > mb_count) mb_cursor = mb_count;
    case (op)
      OP_APPEND: begin
        if (mb_count >= DEPTH) begin
          res.err = ERR_FULL;
        end else begin
          mb_slots[mb_count] = word;
          mb_count++;
        end
      end
      OP_REMOVE: begin
        if (mb_cursor < mb_count) begin
          for (int i = mb_cursor; i + 1 < mb_count; i++) mb_slots[i] = mb_slots[i + 1];
          mb_count--;
          if (mark_set && mb_cursor < mark_pos) mark_pos--;
        end else begin
          res.err = ERR_EMPTY;
        end
        mb_cursor = 0;
      end
      OP_STEP: begin
        if (mb_cursor < mb_count) mb_cursor++;
        else mb_cursor = 0;
      end
      OP_MARK: begin
        mark_tag = label;
        mark_pos = mb_count;
        mark_set = 1'b1;
      end
      OP_RESTORE: begin
        if (mark_set && mark_tag == label)
          mb_cursor = (mark_pos > mb_count) ? mb_count : mark_pos;
      end
      default: ;
    endcase
    if (mb_cursor < mb_count) begin
      res.word    = mb_slots[mb_cursor];
      res.present = 1'b1;
    end
    res.count = mb_count[COUNT_W-1:0];
    return res;
  endfunction

  // Offers one item after a random gap, waits for acceptance, queues its result
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word,
                           input logic [LABEL_W-1:0] label, input logic typed,
                           input mbox_result_t want);
    int           gap;
    mbox_result_t predicted;
    gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {label, word};
    do @(posedge clk); while (!s_tready);
    predicted = mailbox_apply(op, word, label);
    if (typed) predicted = want;
    pending_results = {pending_results, predicted};
  endtask

  // Result side: random stalls, each result checked against the oldest expectation
  initial begin
    mbox_result_t got;
    mbox_result_t want;
    int           stall;
    int           seen;
    logic         recv_calm;
    m_tready  = 1'b0;
    seen      = 0;
    recv_calm = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (seen % 50 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      seen++;
      got = mbox_result_t'(m_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.word !== want.word) begin
          $error("current_value: expected %0h, got %0h", want.word, got.word);
          error_count++;
        end
        if (got.present !== want.present) begin
          $error("current_present: expected %0h, got %0h", want.present, got.present);
          error_count++;
        end
        if (got.err !== want.err) begin
          $error("error_code: expected %0h, got %0h", want.err, got.err);
          error_count++;
        end
        if (got.count !== want.count) begin
          $error("message_count: expected %0h, got %0h", want.count, got.count);
          error_count++;
        end
      end
    end
  end

  // Run limit well above the slowest legal run
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Reset, directed table, random mix, drain
  initial begin
    int                 mode;
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] word;
    logic [LABEL_W-1:0] label;
    logic               found;
    error_count = 0;
    send_calm   = 1'b0;
    mb_count    = 0;
    mb_cursor   = 0;
    mark_pos    = 0;
    mark_tag    = '0;
    mark_set    = 1'b0;
    foreach (mb_slots[i]) mb_slots[i] = '0;
    mode = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_READ;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        word = directed_rows[r].word;
        if (directed_rows[r].reps > 1 && directed_rows[r].op == OP_APPEND)
          word = {$urandom(), $urandom()};
        send_item(directed_rows[r].op, word, directed_rows[r].label,
                  directed_rows[r].typed && directed_rows[r].reps == 1, directed_rows[r].want);
      end
    end

    // random part: modes bias the mix toward filling, draining or scanning
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n % 60 == 0) send_calm = ($urandom_range(0, 3) == 0);

      // let the block run dry now and then
      if ((n == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) && pending_results.size() != 0) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end

      pick  = $urandom_range(0, 99);
      found = 1'b0;
      op    = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
      for (int j = 0; j < 6; j++) begin
        if (!found && pick < OP_CUTS[mode][j]) begin
          op    = OP_ORDER[j];
          found = 1'b1;
        end
      end

      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = ALL_ONES_WORD;
        default: word = {$urandom(), $urandom()};
      endcase

      // restores mostly hit the live mark; marks mostly reuse a few labels
      label = $urandom();
      if (op == OP_RESTORE && $urandom_range(0, 3) != 0) label = mark_tag;
      else if ($urandom_range(0, 4) < 3) label = label_pool[$urandom_range(0, 3)];

      send_item(op, word, label, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
